// ----- rtl/svs_pkg.sv -----
// ----------------------------------------------------------------------------
// svs_pkg
// Shared types, codes and constants of the sprite vertex setup unit.
// ----------------------------------------------------------------------------
package svs_pkg;

  localparam int MAX_VERTICES_DEF = 65536;
  localparam int SINE_DEPTH_DEF   = 256;

  // primitive codes
  localparam logic [1:0] PRIM_TRI    = 2'd0;
  localparam logic [1:0] PRIM_RECT   = 2'd1;
  localparam logic [1:0] PRIM_SPRITE = 2'd2;
  localparam logic [1:0] PRIM_NONE   = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_RIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TOP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_BOTTOM = 2'd3;

  localparam logic signed [31:0] VIEW_LEFT_RST   = 32'sd0;
  localparam logic signed [31:0] VIEW_RIGHT_RST  = 32'sd65536;
  localparam logic signed [31:0] VIEW_TOP_RST    = 32'sd0;
  localparam logic signed [31:0] VIEW_BOTTOM_RST = 32'sd65536;

  // fixed point constants, signed Q3.14 (TEX_HALF unsigned Q0.16)
  localparam logic signed [17:0] Q14_ONE  = 18'sd16384;
  localparam logic signed [17:0] Q14_HALF = 18'sd8192;
  localparam logic [15:0]        TEX_HALF = 16'h8000;

  localparam logic [2:0] TRI_LAST  = 3'd2;
  localparam logic [2:0] QUAD_LAST = 3'd5;

  // divider quotient bits, enough to decide saturation
  localparam int QUO_W     = 18;
  localparam int DIV_STEPS = QUO_W;

  // settle times of the free running datapath, in wait cycles
  localparam int CNT_W     = 5;
  localparam logic [CNT_W-1:0] LAT_FIRST = 5'd10;
  localparam logic [CNT_W-1:0] LAT_NEXT  = 5'd5;
  localparam logic [CNT_W-1:0] DIV_LAST  = 5'(DIV_STEPS - 1);

  typedef struct packed {
    logic [1:0]  primitive_req;
    logic [1:0]  flip;
    logic [63:0] position;
    logic [31:0] scale;
    logic [31:0] extent;
    logic [31:0] pivot;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [31:0] color;
    logic [15:0] rotation;
    logic        frame_start;
  } svs_in_t;

  typedef struct packed {
    logic [15:0]        vertex_index;
    logic signed [15:0] clip_x;
    logic signed [15:0] clip_y;
    logic [31:0]        tex_coord;
    logic [31:0]        vertex_color;
    logic               last;
  } svs_out_t;

  typedef struct packed {
    logic latch;
    logic div_load;
    logic div_step;
    logic out_load;
    logic next_vertex;
  } svs_cmd_t;

  typedef struct packed {
    logic in_nop;
    logic last_vertex;
  } svs_sts_t;

  // quad corner of vertex k: x bit
  function automatic logic corner_x(input logic [2:0] k);
    logic r;
    unique case (k)
      3'd1, 3'd2, 3'd4: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  // quad corner of vertex k: y bit
  function automatic logic corner_y(input logic [2:0] k);
    logic r;
    unique case (k)
      3'd2, 3'd4, 3'd5: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] tri_x(input logic [2:0] k);
    logic signed [17:0] r;
    unique case (k)
      3'd0:    r = -Q14_HALF;
      3'd1:    r = Q14_HALF;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] tri_y(input logic [2:0] k);
    logic signed [17:0] r;
    unique case (k)
      3'd0, 3'd1: r = Q14_HALF;
      default:    r = -Q14_HALF;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/svs_div.sv -----
// ----------------------------------------------------------------------------
// svs_div
// Restoring divider, one quotient bit per step, with overflow flag.
// ----------------------------------------------------------------------------
module svs_div (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic                       step_i,
  input  logic [64:0]                num_i,
  input  logic [32:0]                den_i,
  input  logic                       neg_i,
  output logic [svs_pkg::QUO_W-1:0]  quo_o,
  output logic                       ovf_o,
  output logic                       neg_o
);

  localparam int QW = svs_pkg::QUO_W;

  logic [32:0]   rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic          ovf_q, ovf_d;
  logic          neg_q, neg_d;
  logic [33:0]   shifted;
  logic [33:0]   diff;
  logic          ge;

  always_comb begin
    shifted = {rem_q, quo_q[QW-1]};
    diff    = shifted - {1'b0, den_i};
    ge      = shifted >= {1'b0, den_i};
    rem_d   = rem_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    neg_d   = neg_q;
    if (load_i) begin
      // quotient would not fit: saturate later
      ovf_d = num_i >= 65'({den_i, {QW{1'b0}}});
      rem_d = num_i[QW+32:QW];
      quo_d = num_i[QW-1:0];
      neg_d = neg_i;
    end else if (step_i) begin
      rem_d = ge ? diff[32:0] : shifted[32:0];
      quo_d = {quo_q[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
    neg_q <= neg_d;
  end

  assign quo_o = quo_q;
  assign ovf_o = ovf_q;
  assign neg_o = neg_q;

endmodule

// ----- rtl/svs_trig.sv -----
// ----------------------------------------------------------------------------
// svs_trig
// Sine and cosine of the quantized rotation angle, polynomial in five stages.
// ----------------------------------------------------------------------------
module svs_trig #(
  parameter int SINE_TABLE_DEPTH = svs_pkg::SINE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic [15:0]        rotation_i,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
  // floor(idx * 65536 / depth) as multiply by reciprocal
  localparam logic [35:0] RECIP =
    36'(((64'd1 << 41) + 64'(SINE_TABLE_DEPTH) - 64'd1) / 64'(SINE_TABLE_DEPTH));

  logic [15+DW:0] idx_prod;
  logic [IW-1:0]  idx_q;
  logic [IW+35:0] ang_prod;
  logic [15:0]    ang_q;
  logic [15:0]    ang_l [2];
  logic [14:0]    z_q   [2];
  logic           neg_q [2];
  logic [14:0]    z2_q  [2];
  logic [13:0]    t1_q  [2];
  logic [14:0]    t2_q  [2];
  logic signed [15:0] val_q [2];
  logic [29:0]    m_z2  [2];
  logic [25:0]    m_t1  [2];
  logic [28:0]    m_t2  [2];
  logic [29:0]    m_t3  [2];

  always_comb begin
    idx_prod = (16+DW)'(rotation_i) * (16+DW)'(SINE_TABLE_DEPTH);
    ang_prod = (IW+36)'(idx_q) * (IW+36)'(RECIP);
    ang_l[0] = ang_q;
    ang_l[1] = ang_q + 16'h4000;
    for (int l = 0; l < 2; l++) begin
      m_z2[l] = 30'(z_q[l]) * 30'(z_q[l]);
      m_t1[l] = 26'(z2_q[l]) * 26'd1160;
      m_t2[l] = 29'(t1_q[l]) * 29'(z2_q[l]);
      m_t3[l] = 30'(t2_q[l]) * 30'(z_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_prod[15+IW:16];
    ang_q <= ang_prod[40:25];
    for (int l = 0; l < 2; l++) begin
      // mirror odd quadrants, negate the second half turn
      z_q[l]   <= ang_l[l][14] ? 15'(15'd16384 - 15'(ang_l[l][13:0]))
                               : 15'(ang_l[l][13:0]);
      neg_q[l] <= ang_l[l][15];
      z2_q[l]  <= m_z2[l][28:14];
      t1_q[l]  <= 14'(14'd10512 - 14'(m_t1[l][25:14]));
      t2_q[l]  <= 15'(15'd25736 - 15'(m_t2[l][28:14]));
      val_q[l] <= neg_q[l] ? -$signed({1'b0, m_t3[l][28:14]})
                           : $signed({1'b0, m_t3[l][28:14]});
    end
  end

  assign sin_o = val_q[0];
  assign cos_o = val_q[1];

endmodule

// ----- rtl/svs_ctrl.sv -----
// ----------------------------------------------------------------------------
// svs_ctrl
// Sequencer: settle wait, divide steps and vertex output handshake.
// ----------------------------------------------------------------------------
module svs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  input  svs_pkg::svs_sts_t sts_i,
  output svs_pkg::svs_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [svs_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          if (!sts_i.in_nop) begin
            state_d = ST_WAIT;
            cnt_d   = svs_pkg::LAT_FIRST;
          end
        end
      end
      ST_WAIT: begin
        if (cnt_q == '0) begin
          cmd_o.div_load = 1'b1;
          state_d        = ST_DIV;
          cnt_d          = svs_pkg::DIV_LAST;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          if (sts_i.last_vertex) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.next_vertex = 1'b1;
            state_d           = ST_WAIT;
            cnt_d             = svs_pkg::LAT_NEXT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/svs_dp.sv -----
// ----------------------------------------------------------------------------
// svs_dp
// Datapath: command and view registers, transform stages, dividers, output.
// ----------------------------------------------------------------------------
module svs_dp #(
  parameter int MAX_VERTICES     = svs_pkg::MAX_VERTICES_DEF,
  parameter int SINE_TABLE_DEPTH = svs_pkg::SINE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  svs_pkg::svs_in_t                in_data_i,
  input  logic                            cfg_write_i,
  input  logic [svs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  input  svs_pkg::svs_cmd_t               cmd_i,
  output svs_pkg::svs_sts_t               sts_o,
  output svs_pkg::svs_out_t               out_data_o
);

  localparam int VC_W = $clog2(MAX_VERTICES);
  localparam int QW   = svs_pkg::QUO_W;

  svs_pkg::svs_in_t   cmd_q;
  logic [2:0]         k_q;
  logic [VC_W-1:0]    vcnt_q;
  logic [VC_W+15:0]   vcnt_wide;
  logic signed [31:0] left_q, right_q, top_q, bottom_q;
  svs_pkg::svs_out_t  out_q;

  logic signed [15:0] sin_v, cos_v;
  logic signed [17:0] ox, oy;
  logic signed [15:0] piv_x, piv_y, scl_x, scl_y;
  logic [15:0]        u0, u1, v0, v1, tu, tv;
  logic               cbx, cby;

  logic signed [34:0] p_x_q, p_y_q;
  logic signed [50:0] l_prod_x, l_prod_y;
  logic signed [44:0] l_x_q, l_y_q;
  logic signed [60:0] m_xc_q, m_ys_q, m_xs_q, m_yc_q;
  logic signed [61:0] sum_x, sum_y;
  logic signed [48:0] w_x_q, w_y_q;
  logic signed [49:0] diff_x, diff_y;
  logic [49:0]        mag_x, mag_y;
  logic [64:0]        num_x_q, num_y_q;
  logic               nneg_x_q, nneg_y_q;
  logic signed [32:0] den_x, den_y;
  logic [32:0]        dmag_x_q, dmag_y_q;
  logic               dneg_x_q, dneg_y_q, dzero_x_q, dzero_y_q;

  logic [QW-1:0]      quo_x, quo_y;
  logic               ovf_x, ovf_y, qneg_x, qneg_y;

  function automatic logic signed [15:0] clip_calc(input logic zero, input logic ovf,
                                                   input logic neg, input logic mirror,
                                                   input logic [QW-1:0] quo);
    logic signed [QW+1:0] qs;
    logic signed [QW+1:0] v;
    logic signed [15:0]   r;
    qs = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    v  = mirror ? (20'sd16384 - qs) : (qs - 20'sd16384);
    if (zero) begin
      r = 16'sd0;
    end else if (ovf) begin
      r = (neg ^ mirror) ? 16'sh8000 : 16'sh7FFF;
    end else if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic svs_pkg::svs_out_t out_data_next();
    svs_pkg::svs_out_t o;
    o.vertex_index = vcnt_wide[15:0];
    o.clip_x       = clip_calc(dzero_x_q, ovf_x, qneg_x, 1'b0, quo_x);
    o.clip_y       = clip_calc(dzero_y_q, ovf_y, qneg_y, 1'b1, quo_y);
    o.tex_coord    = {tu, tv};
    o.vertex_color = cmd_q.color;
    o.last         = sts_o.last_vertex;
    return o;
  endfunction

  svs_trig #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_trig (
    .clk_i      (clk_i),
    .rotation_i (cmd_q.rotation),
    .sin_o      (sin_v),
    .cos_o      (cos_v)
  );

  // vertex counter and view registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q   <= '0;
      left_q   <= svs_pkg::VIEW_LEFT_RST;
      right_q  <= svs_pkg::VIEW_RIGHT_RST;
      top_q    <= svs_pkg::VIEW_TOP_RST;
      bottom_q <= svs_pkg::VIEW_BOTTOM_RST;
    end else begin
      if (cmd_i.latch && in_data_i.frame_start) begin
        vcnt_q <= '0;
      end else if (cmd_i.out_load) begin
        vcnt_q <= (vcnt_q == VC_W'(MAX_VERTICES - 1)) ? '0 : vcnt_q + 1'b1;
      end
      if (cfg_write_i) begin
        unique case (cfg_index_i)
          svs_pkg::CFG_VIEW_LEFT:   left_q   <= cfg_data_i;
          svs_pkg::CFG_VIEW_RIGHT:  right_q  <= cfg_data_i;
          svs_pkg::CFG_VIEW_TOP:    top_q    <= cfg_data_i;
          svs_pkg::CFG_VIEW_BOTTOM: bottom_q <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= in_data_i;
      k_q   <= 3'd0;
    end else if (cmd_i.next_vertex) begin
      k_q <= k_q + 3'd1;
    end
    if (cmd_i.out_load) begin
      out_q <= out_data_next();
    end
  end

  // local offset and texture corner of the current vertex
  always_comb begin
    piv_x = cmd_q.pivot[31:16];
    piv_y = cmd_q.pivot[15:0];
    scl_x = cmd_q.scale[31:16];
    scl_y = cmd_q.scale[15:0];
    cbx   = svs_pkg::corner_x(k_q);
    cby   = svs_pkg::corner_y(k_q);
    u0    = cmd_q.flip[0] ? cmd_q.tex_u[15:0]  : cmd_q.tex_u[31:16];
    u1    = cmd_q.flip[0] ? cmd_q.tex_u[31:16] : cmd_q.tex_u[15:0];
    v0    = cmd_q.flip[1] ? cmd_q.tex_v[15:0]  : cmd_q.tex_v[31:16];
    v1    = cmd_q.flip[1] ? cmd_q.tex_v[31:16] : cmd_q.tex_v[15:0];
    unique case (cmd_q.primitive_req)
      svs_pkg::PRIM_TRI: begin
        ox = svs_pkg::tri_x(k_q);
        oy = svs_pkg::tri_y(k_q);
        tu = svs_pkg::TEX_HALF;
        tv = svs_pkg::TEX_HALF;
      end
      svs_pkg::PRIM_SPRITE: begin
        ox = (cbx ? svs_pkg::Q14_ONE : 18'sd0) - 18'(piv_x);
        oy = (cby ? svs_pkg::Q14_ONE : 18'sd0) - 18'(piv_y);
        tu = cbx ? u1 : u0;
        tv = cby ? v1 : v0;
      end
      default: begin
        ox = cbx ? svs_pkg::Q14_HALF : -svs_pkg::Q14_HALF;
        oy = cby ? svs_pkg::Q14_HALF : -svs_pkg::Q14_HALF;
        tu = cbx ? u1 : u0;
        tv = cby ? v1 : v0;
      end
    endcase
  end

  // transform stages, free running off the held command
  always_comb begin
    l_prod_x = 51'(p_x_q) * 51'(scl_x);
    l_prod_y = 51'(p_y_q) * 51'(scl_y);
    sum_x    = 62'(m_xc_q) - 62'(m_ys_q);
    sum_y    = 62'(m_xs_q) + 62'(m_yc_q);
    diff_x   = 50'(w_x_q) - 50'(left_q);
    diff_y   = 50'(w_y_q) - 50'(top_q);
    mag_x    = diff_x[49] ? 50'(-diff_x) : 50'(diff_x);
    mag_y    = diff_y[49] ? 50'(-diff_y) : 50'(diff_y);
    den_x    = 33'(right_q) - 33'(left_q);
    den_y    = 33'(bottom_q) - 33'(top_q);
  end

  always_ff @(posedge clk_i) begin
    p_x_q    <= 35'(ox) * 35'($signed({1'b0, cmd_q.extent[31:16]}));
    p_y_q    <= 35'(oy) * 35'($signed({1'b0, cmd_q.extent[15:0]}));
    l_x_q    <= 45'(l_prod_x >>> 6);
    l_y_q    <= 45'(l_prod_y >>> 6);
    m_xc_q   <= 61'(l_x_q) * 61'(cos_v);
    m_ys_q   <= 61'(l_y_q) * 61'(sin_v);
    m_xs_q   <= 61'(l_x_q) * 61'(sin_v);
    m_yc_q   <= 61'(l_y_q) * 61'(cos_v);
    w_x_q    <= 49'($signed(cmd_q.position[63:32])) + 49'(sum_x >>> 14);
    w_y_q    <= 49'($signed(cmd_q.position[31:0])) + 49'(sum_y >>> 14);
    num_x_q  <= {mag_x, 15'b0};
    num_y_q  <= {mag_y, 15'b0};
    nneg_x_q <= diff_x[49];
    nneg_y_q <= diff_y[49];
    dmag_x_q  <= den_x[32] ? 33'(-den_x) : 33'(den_x);
    dmag_y_q  <= den_y[32] ? 33'(-den_y) : 33'(den_y);
    dneg_x_q  <= den_x[32];
    dneg_y_q  <= den_y[32];
    dzero_x_q <= den_x == '0;
    dzero_y_q <= den_y == '0;
  end

  svs_div u_div_x (
    .clk_i  (clk_i),
    .load_i (cmd_i.div_load),
    .step_i (cmd_i.div_step),
    .num_i  (num_x_q),
    .den_i  (dmag_x_q),
    .neg_i  (nneg_x_q ^ dneg_x_q),
    .quo_o  (quo_x),
    .ovf_o  (ovf_x),
    .neg_o  (qneg_x)
  );

  svs_div u_div_y (
    .clk_i  (clk_i),
    .load_i (cmd_i.div_load),
    .step_i (cmd_i.div_step),
    .num_i  (num_y_q),
    .den_i  (dmag_y_q),
    .neg_i  (nneg_y_q ^ dneg_y_q),
    .quo_o  (quo_y),
    .ovf_o  (ovf_y),
    .neg_o  (qneg_y)
  );

  assign vcnt_wide         = (VC_W+16)'(vcnt_q);
  assign sts_o.in_nop      = in_data_i.primitive_req == svs_pkg::PRIM_NONE;
  assign sts_o.last_vertex = k_q == ((cmd_q.primitive_req == svs_pkg::PRIM_TRI) ?
                                     svs_pkg::TRI_LAST : svs_pkg::QUAD_LAST);
  assign out_data_o        = out_q;

endmodule

// ----- rtl/sprite_vertex_setup_unit.sv -----
// ----------------------------------------------------------------------------
// sprite_vertex_setup_unit
// Turns one draw command into 3 or 6 transformed clip-space vertices.
// ----------------------------------------------------------------------------
// Input channel in_valid_i / in_stall_o carries one draw command word; it is
// taken at an edge with valid high and stall low. Output channel
// out_valid_o / out_stall_i carries one vertex word; the last vertex of a
// command has last set. Commands with primitive code 3 produce no vertices.
// Per vertex, the sequencer waits for the transform pipeline to settle,
// loads the two one-bit-per-cycle clip dividers, steps them and then loads
// the output register. The first vertex also waits for the sine/cosine
// polynomial. The next command is taken the cycle after the last vertex
// enters the output register, while that vertex may still wait. A stalled
// receiver holds the output word and pauses generation of the next vertex.
// View registers are written on cfg_valid_i/cfg_ready_o (always ready); the
// user must write them only while no command is in flight, which the block
// itself does not enforce. Reset clears the vertex counter, the sequencer
// and the output valid, and loads the default view bounds.
// ----------------------------------------------------------------------------
module sprite_vertex_setup_unit #(
  parameter int MAX_VERTICES     = svs_pkg::MAX_VERTICES_DEF,
  parameter int SINE_TABLE_DEPTH = svs_pkg::SINE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  svs_pkg::svs_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output svs_pkg::svs_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [svs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  svs_pkg::svs_cmd_t cmd;
  svs_pkg::svs_sts_t sts;

  assign cfg_ready_o = 1'b1;

  svs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  svs_dp #(
    .MAX_VERTICES     (MAX_VERTICES),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/svs_checker.sv -----
// ----------------------------------------------------------------------------
// svs_checker
// Port level checks of the sprite vertex setup unit, bound to the top level.
// ----------------------------------------------------------------------------
module svs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input svs_pkg::svs_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input svs_pkg::svs_out_t out_data_o
);

  // a real command, once taken, raises the input stall
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.primitive_req != svs_pkg::PRIM_NONE
    |=> in_stall_o)
    else $error("command taken but input not stalled");

  // no new command while a vertex other than the last is pending
  a_no_cmd_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input open in the middle of a command");

  // an idle unit with no word pending stays silent
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_stall_o |=> !out_valid_o)
    else $error("vertex word out of an idle unit");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

endmodule

bind sprite_vertex_setup_unit svs_checker u_svs_checker (.*);
